@@ design/spot_centroid_center_of_gravity_defines.svh @@
// assertion macros used by the spot centroid controller
`ifndef SPOT_CENTROID_CENTER_OF_GRAVITY_DEFINES_SVH
`define SPOT_CENTROID_CENTER_OF_GRAVITY_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SCOG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scog assertion failed");

// next-cycle implication, disabled while reset is low
`define SCOG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scog assertion failed");

`endif

@@ design/scog_pkg.sv @@
`default_nettype none

package scog_pkg;

    // sizing of the region and the pixel
    localparam int MAX_SIDE   = 1024;
    localparam int PIXEL_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // port widths
    localparam int PIX_W      = 16;
    localparam int THR_W      = 16;
    localparam int DIM_W      = 11;
    localparam int CENT_W     = 18;
    localparam int PEAK_W     = 16;
    localparam int FLUX_OUT_W = 36;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // internal widths
    localparam int SIDE_W  = $clog2(MAX_SIDE);
    localparam int FLUX_W  = PIXEL_BITS + 2 * SIDE_W;
    localparam int WSUM_W  = FLUX_W + SIDE_W;
    localparam int QUO_W   = SIDE_W + FRAC_BITS + 1;
    localparam int NUM_W   = WSUM_W + FRAC_BITS;
    localparam int STEP_W  = $clog2(QUO_W + 1);

    // saturation limits of the result fields
    localparam int          CENT_MAX = (1 << CENT_W) - 1;
    localparam logic [63:0] FLUX_MAX = (64'd1 << FLUX_OUT_W) - 64'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT = CFG_IDX_W'(2);

    // register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = '0;
    localparam logic [DIM_W-1:0] ROI_WIDTH_RST  = DIM_W'(64);
    localparam logic [DIM_W-1:0] ROI_HEIGHT_RST = DIM_W'(64);

    // active configuration, sides already clamped to 1..MAX_SIDE
    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SIDE_W:0]   roi_w;
        logic [SIDE_W:0]   roi_h;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic accum;
        logic div_start;
        logic div_sel_y;
        logic store_x;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic flux_zero;
        logic div_done;
    } t_dp_stat;

    // zero reads as one, anything above MAX_SIDE as MAX_SIDE
    function automatic logic [SIDE_W:0] clamp_side(input logic [DIM_W-1:0] s);
        logic [SIDE_W:0] r;
        if (s == '0) begin
            r = (SIDE_W+1)'(1);
        end else if (32'(s) > 32'(MAX_SIDE)) begin
            r = (SIDE_W+1)'(MAX_SIDE);
        end else begin
            r = (SIDE_W+1)'(s);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/scog_regs.sv @@
`default_nettype none

module scog_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [scog_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scog_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output scog_pkg::t_cfg                   o_cfg
);
    import scog_pkg::*;

    logic [THR_W-1:0] r_threshold;
    logic [DIM_W-1:0] r_roi_width;
    logic [DIM_W-1:0] r_roi_height;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RST;
            r_roi_width  <= ROI_WIDTH_RST;
            r_roi_height <= ROI_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THRESHOLD:  r_threshold  <= i_cfg_data[THR_W-1:0];
                REG_ROI_WIDTH:  r_roi_width  <= i_cfg_data[DIM_W-1:0];
                REG_ROI_HEIGHT: r_roi_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped view used by the datapath
    assign o_cfg.threshold = r_threshold;
    assign o_cfg.roi_w     = clamp_side(r_roi_width);
    assign o_cfg.roi_h     = clamp_side(r_roi_height);

endmodule

`default_nettype wire

@@ design/scog_div.sv @@
`default_nettype none

module scog_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [scog_pkg::NUM_W-1:0]   i_num,
    input  logic [scog_pkg::FLUX_W-1:0]  i_den,
    output logic                         o_done,
    output logic [scog_pkg::QUO_W-1:0]   o_quo
);
    import scog_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [FLUX_W-1:0]   r_rem;
    logic [FLUX_W-1:0]   r_den;
    logic [QUO_W-1:0]    r_nlo;
    logic [QUO_W-1:0]    r_quo;
    logic [FLUX_W:0]     trial;
    logic [FLUX_W:0]     diff;
    logic                ge;

    // one restoring step: bring down the next numerator bit
    always_comb begin
        trial = {r_rem, r_nlo[QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUO_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient; the upper numerator part is below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= FLUX_W'(i_num[NUM_W-1:QUO_W]);
            r_nlo <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[FLUX_W-1:0] : trial[FLUX_W-1:0];
            r_nlo <= {r_nlo[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

@@ design/scog_dp.sv @@
`default_nettype none

module scog_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scog_pkg::t_cfg                   i_cfg,
    input  scog_pkg::t_dp_cmd                i_cmd,
    output scog_pkg::t_dp_stat               o_stat,
    input  logic [scog_pkg::PIX_W-1:0]       i_pixel,
    input  logic                             i_frame_first,
    output logic [scog_pkg::CENT_W-1:0]      o_centroid_x,
    output logic [scog_pkg::CENT_W-1:0]      o_centroid_y,
    output logic                             o_spot_valid,
    output logic [scog_pkg::PEAK_W-1:0]      o_peak_level,
    output logic [scog_pkg::FLUX_OUT_W-1:0]  o_total_flux
);
    import scog_pkg::*;

    localparam int PROD_W = SIDE_W + PIXEL_BITS;

    logic [SIDE_W-1:0]      r_col;
    logic [SIDE_W-1:0]      r_row;
    logic [WSUM_W-1:0]      r_wsum_x;
    logic [WSUM_W-1:0]      r_wsum_y;
    logic [FLUX_W-1:0]      r_flux;
    logic [PIXEL_BITS-1:0]  r_peak;
    logic [CENT_W-1:0]      r_cx;

    logic [CENT_W-1:0]      r_out_cx;
    logic [CENT_W-1:0]      r_out_cy;
    logic                   r_out_valid_flag;
    logic [PEAK_W-1:0]      r_out_peak;
    logic [FLUX_OUT_W-1:0]  r_out_flux;

    logic [PIXEL_BITS-1:0]  pix_v;
    logic [PIXEL_BITS-1:0]  kept;
    logic [SIDE_W-1:0]      col_now;
    logic [SIDE_W-1:0]      row_now;
    logic [SIDE_W:0]        col_inc;
    logic [SIDE_W:0]        row_inc;
    logic                   col_wrap;
    logic                   row_wrap;
    logic [WSUM_W-1:0]      base_x;
    logic [WSUM_W-1:0]      base_y;
    logic [FLUX_W-1:0]      base_flux;
    logic [PIXEL_BITS-1:0]  base_peak;
    logic [PROD_W-1:0]      prod_x;
    logic [PROD_W-1:0]      prod_y;
    logic [WSUM_W-1:0]      n_wsum_x;
    logic [WSUM_W-1:0]      n_wsum_y;
    logic [FLUX_W-1:0]      n_flux;
    logic [PIXEL_BITS-1:0]  n_peak;

    logic [NUM_W-1:0]       div_num;
    logic [QUO_W-1:0]       div_quo;
    logic                   div_done;
    logic [CENT_W-1:0]      quo_sat;
    logic [FLUX_OUT_W-1:0]  flux_sat;
    logic                   flux_zero;

    // threshold to zero
    always_comb begin
        pix_v = i_pixel[PIXEL_BITS-1:0];
        kept  = (THR_W'(pix_v) > i_cfg.threshold) ? pix_v : '0;
    end

    // frame start restarts position and sums
    always_comb begin
        col_now   = i_frame_first ? '0 : r_col;
        row_now   = i_frame_first ? '0 : r_row;
        base_x    = i_frame_first ? '0 : r_wsum_x;
        base_y    = i_frame_first ? '0 : r_wsum_y;
        base_flux = i_frame_first ? '0 : r_flux;
        base_peak = i_frame_first ? '0 : r_peak;
    end

    // raster position and end of region
    always_comb begin
        col_inc  = {1'b0, col_now} + (SIDE_W+1)'(1);
        row_inc  = {1'b0, row_now} + (SIDE_W+1)'(1);
        col_wrap = (col_inc >= i_cfg.roi_w);
        row_wrap = (row_inc >= i_cfg.roi_h);
    end

    // weighted and plain accumulation
    always_comb begin
        prod_x   = PROD_W'(col_now) * PROD_W'(kept);
        prod_y   = PROD_W'(row_now) * PROD_W'(kept);
        n_wsum_x = base_x + WSUM_W'(prod_x);
        n_wsum_y = base_y + WSUM_W'(prod_y);
        n_flux   = base_flux + FLUX_W'(kept);
        n_peak   = (kept > base_peak) ? kept : base_peak;
    end

    // accumulator state; held after the last pixel until the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_wsum_x <= '0;
            r_wsum_y <= '0;
            r_flux   <= '0;
            r_peak   <= '0;
        end else if (i_cmd.accum) begin
            r_col    <= col_wrap ? '0 : col_inc[SIDE_W-1:0];
            r_row    <= col_wrap ? (row_wrap ? '0 : row_inc[SIDE_W-1:0]) : row_now;
            r_wsum_x <= n_wsum_x;
            r_wsum_y <= n_wsum_y;
            r_flux   <= n_flux;
            r_peak   <= n_peak;
        end else if (i_cmd.load_out) begin
            r_wsum_x <= '0;
            r_wsum_y <= '0;
            r_flux   <= '0;
            r_peak   <= '0;
        end
    end

    // rounded quotient: (sum << frac + flux / 2) / flux
    assign div_num = (NUM_W'(i_cmd.div_sel_y ? r_wsum_y : r_wsum_x) << FRAC_BITS)
                   + NUM_W'(r_flux >> 1);

    scog_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_flux),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // saturation to the field widths
    always_comb begin
        flux_zero = (r_flux == '0);
        quo_sat   = (32'(div_quo) > 32'(CENT_MAX)) ? CENT_W'(CENT_MAX) : CENT_W'(div_quo);
        flux_sat  = (64'(r_flux) > FLUX_MAX) ? FLUX_OUT_W'(FLUX_MAX) : FLUX_OUT_W'(r_flux);
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_x) begin
            r_cx <= quo_sat;
        end
        if (i_cmd.load_out) begin
            r_out_cx         <= flux_zero ? '0 : r_cx;
            r_out_cy         <= flux_zero ? '0 : quo_sat;
            r_out_valid_flag <= !flux_zero;
            r_out_peak       <= flux_zero ? '0 : PEAK_W'(r_peak);
            r_out_flux       <= flux_zero ? '0 : flux_sat;
        end
    end

    assign o_stat.last      = col_wrap && row_wrap;
    assign o_stat.flux_zero = flux_zero;
    assign o_stat.div_done  = div_done;

    assign o_centroid_x = r_out_cx;
    assign o_centroid_y = r_out_cy;
    assign o_spot_valid = r_out_valid_flag;
    assign o_peak_level = r_out_peak;
    assign o_total_flux = r_out_flux;

endmodule

`default_nettype wire

@@ design/scog_ctrl.sv @@
`default_nettype none

`include "spot_centroid_center_of_gravity_defines.svh"

module scog_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  scog_pkg::t_dp_stat   i_stat,
    output scog_pkg::t_dp_cmd    o_cmd
);
    import scog_pkg::*;

    typedef enum logic [2:0] {
        S_ACCUM,
        S_CHECK,
        S_DIVX,
        S_DIVY,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_ready;
    logic   load_ok;
    logic   dividing;

    // commands and next state
    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        load_ok   = !r_out_valid || i_out_ready;
        o_cmd     = '0;
        case (r_state)
            S_ACCUM: begin
                in_ready    = 1'b1;
                o_cmd.accum = i_in_valid;
                if (i_in_valid && i_stat.last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.flux_zero) begin
                    n_state = S_LOAD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVX;
                end
            end
            S_DIVX: begin
                if (i_stat.div_done) begin
                    o_cmd.store_x   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                    n_state         = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.div_sel_y = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.div_sel_y = 1'b1;
                if (load_ok) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACCUM;
                end
            end
            default: begin
                n_state = S_ACCUM;
            end
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    // either division in progress
    assign dividing = (r_state == S_DIVX) || (r_state == S_DIVY);

    // checks
    `SCOG_ASSERT_NOW(a_load_room, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_out_ready)
    `SCOG_ASSERT_NOW(a_done_when_waiting, i_clk, i_rst_n, i_stat.div_done, dividing)
    `SCOG_ASSERT_NOW(a_div_nonzero_flux, i_clk, i_rst_n, dividing, !i_stat.flux_zero)
    `SCOG_ASSERT_NEXT(a_last_to_check, i_clk, i_rst_n, o_cmd.accum && i_stat.last, r_state == S_CHECK)

endmodule

`default_nettype wire

@@ design/spot_centroid_center_of_gravity.sv @@
`default_nettype none

// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+---------------------------------
// pixel in  | input     | i_in_valid / o_in_ready     | i_pixel, i_frame_first
// result    | output    | o_out_valid / i_out_ready   | o_centroid_x/y, o_spot_valid,
//           |           |                             | o_peak_level, o_total_flux
// config    | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// pixels are taken one per cycle while a region is being summed
// after the last pixel of a region: a check state, then two serial divisions of QUO_W (19)
// restoring steps each on the shared divider, then a load state that waits for room in the
// output register; no pixel is taken meanwhile (the divisions are skipped if flux is zero)
// a result waiting in the output register does not block the next region's pixels
// synchronous active-low reset clears sums, position and registers to defaults

module spot_centroid_center_of_gravity (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [scog_pkg::PIX_W-1:0]       i_pixel,
    input  logic                             i_frame_first,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [scog_pkg::CENT_W-1:0]      o_centroid_x,
    output logic [scog_pkg::CENT_W-1:0]      o_centroid_y,
    output logic                             o_spot_valid,
    output logic [scog_pkg::PEAK_W-1:0]      o_peak_level,
    output logic [scog_pkg::FLUX_OUT_W-1:0]  o_total_flux,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [scog_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scog_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import scog_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // register writes are always accepted
    assign o_cfg_ready = 1'b1;

    scog_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    scog_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pixel       (i_pixel),
        .i_frame_first (i_frame_first),
        .o_centroid_x  (o_centroid_x),
        .o_centroid_y  (o_centroid_y),
        .o_spot_valid  (o_spot_valid),
        .o_peak_level  (o_peak_level),
        .o_total_flux  (o_total_flux)
    );

    scog_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import scog_pkg::*;

    // register index that decodes to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
    // cycles the block may still spend on a region after its last item
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_PIXELS = 2000;

    typedef struct packed {
        logic [CENT_W-1:0]     cx;
        logic [CENT_W-1:0]     cy;
        logic                  valid;
        logic [PEAK_W-1:0]     peak;
        logic [FLUX_OUT_W-1:0] flux;
    } t_spot;

    typedef enum logic {ROW_REG, ROW_PIX} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pix;
        logic                  first;
        bit                    typed;
        t_spot                 want;
    } t_dir_row;

    // block ports
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [PIX_W-1:0]        i_pixel = '0;
    logic                    i_frame_first = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [CENT_W-1:0]       o_centroid_x;
    logic [CENT_W-1:0]       o_centroid_y;
    logic                    o_spot_valid;
    logic [PEAK_W-1:0]       o_peak_level;
    logic [FLUX_OUT_W-1:0]   o_total_flux;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // predictor copy of registers and region state
    logic [THR_W-1:0]        thr_cfg;
    logic [DIM_W-1:0]        width_cfg;
    logic [DIM_W-1:0]        height_cfg;
    int unsigned             col_pos;
    int unsigned             row_pos;
    longint unsigned         moment_x;
    longint unsigned         moment_y;
    longint unsigned         flux_acc;
    int unsigned             peak_acc;

    t_spot                   spot_expect_q[$];
    t_spot                   head_want;
    t_dir_row                directed_q[$];
    int                      err_count = 0;
    bit                      calm = 1'b0;

    spot_centroid_center_of_gravity uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel       (i_pixel),
        .i_frame_first (i_frame_first),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_centroid_x  (o_centroid_x),
        .o_centroid_y  (o_centroid_y),
        .o_spot_valid  (o_spot_valid),
        .o_peak_level  (o_peak_level),
        .o_total_flux  (o_total_flux),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // zero counts as one side, anything past the maximum as the maximum
    function automatic int unsigned side_of(input logic [DIM_W-1:0] s);
        if (s == '0) begin
            return 1;
        end
        if (int'(s) > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(s);
    endfunction

    // rounded fixed point quotient, saturated to the centroid field
    function automatic logic [CENT_W-1:0] cog_fixed(input longint unsigned num,
                                                    input longint unsigned den);
        longint unsigned whole;
        longint unsigned rest;
        longint unsigned frac;
        longint unsigned q;
        longint unsigned top;
        top = longint'(CENT_MAX);
        whole = num / den;
        rest = num % den;
        frac = ((rest << FRAC_BITS) + den / 2) / den;
        if (whole > (top >> FRAC_BITS)) begin
            return '1;
        end
        q = (whole << FRAC_BITS) + frac;
        return (q > top) ? '1 : q[CENT_W-1:0];
    endfunction

    function automatic void restart_region();
        col_pos = 0;
        row_pos = 0;
        moment_x = 0;
        moment_y = 0;
        flux_acc = 0;
        peak_acc = 0;
    endfunction

    function automatic void reg_update(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESHOLD: begin
                thr_cfg = data[THR_W-1:0];
            end
            REG_ROI_WIDTH: begin
                width_cfg = data[DIM_W-1:0];
            end
            REG_ROI_HEIGHT: begin
                height_cfg = data[DIM_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // threshold, accumulate and step the raster position; returns 1 on region end
    function automatic bit accumulate_pixel(input logic [PIX_W-1:0] pix, input logic first,
                                            output t_spot res);
        int unsigned w;
        int unsigned h;
        int unsigned v;
        bit          done;
        w = side_of(width_cfg);
        h = side_of(height_cfg);
        v = pix;
        res = '0;
        done = 1'b0;
        if (first) begin
            restart_region();
        end
        if (v <= thr_cfg) begin
            v = 0;
        end
        moment_x += longint'(col_pos) * v;
        moment_y += longint'(row_pos) * v;
        flux_acc += v;
        if (v > peak_acc) begin
            peak_acc = v;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) begin
                done = 1'b1;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos++;
        end
        if (done) begin
            if (flux_acc > 0) begin
                res.cx = cog_fixed(moment_x, flux_acc);
                res.cy = cog_fixed(moment_y, flux_acc);
                res.valid = 1'b1;
                res.peak = peak_acc[PEAK_W-1:0];
                res.flux = (flux_acc > FLUX_MAX) ? '1 : flux_acc[FLUX_OUT_W-1:0];
            end
            restart_region();
        end
        return done;
    endfunction

    function automatic t_dir_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r = '{kind: ROW_REG, idx: idx, data: data, pix: '0, first: 1'b0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_dir_row pix_row(input logic [PIX_W-1:0] pix, input logic first);
        t_dir_row r;
        r = '{kind: ROW_PIX, idx: '0, data: '0, pix: pix, first: first,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_dir_row known_row(input logic [PIX_W-1:0] pix, input logic first,
                                           input t_spot want);
        t_dir_row r;
        r = '{kind: ROW_PIX, idx: '0, data: '0, pix: pix, first: first,
              typed: 1'b1, want: want};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        err_count++;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // one pixel item; valid stays high afterwards so the next item can follow at once
    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic first,
                              input bit typed, input t_spot want);
        t_spot res;
        bit    done;
        if (!calm && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 31);
        end
        i_in_valid <= 1'b1;
        i_pixel <= pix;
        i_frame_first <= first;
        do @(posedge i_clk); while (!o_in_ready);
        done = accumulate_pixel(pix, first, res);
        if (done) begin
            spot_expect_q.push_back(typed ? want : res);
        end
    endtask

    // stop sending and wait until the block has nothing left in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (spot_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_update(idx, data);
    endtask

    // result receiver stalls at random except during the calm stretch
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (spot_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected", o_total_flux, 0);
            end else begin
                head_want = spot_expect_q.pop_front();
                if (o_centroid_x !== head_want.cx)
                    report_mismatch("centroid_x", o_centroid_x, head_want.cx);
                if (o_centroid_y !== head_want.cy)
                    report_mismatch("centroid_y", o_centroid_y, head_want.cy);
                if (o_spot_valid !== head_want.valid)
                    report_mismatch("spot_valid", o_spot_valid, head_want.valid);
                if (o_peak_level !== head_want.peak)
                    report_mismatch("peak_level", o_peak_level, head_want.peak);
                if (o_total_flux !== head_want.flux)
                    report_mismatch("total_flux", o_total_flux, head_want.flux);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_dir_row            row;
        bit                  quiet;
        int                  rnd_pixels;
        int                  regions;
        int                  area;
        int                  n;
        int                  mode;
        int                  r;
        logic                first;
        logic [PIX_W-1:0]    pix;
        logic [4:0]          junk;
        logic [DIM_W-1:0]    wv;
        logic [DIM_W-1:0]    hv;
        logic [THR_W-1:0]    tv;

        // predictor starts from the reset values
        thr_cfg = THRESHOLD_RST;
        width_cfg = ROI_WIDTH_RST;
        height_cfg = ROI_HEIGHT_RST;
        restart_region();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single pixel regions: full scale, zero flux, smallest nonzero
        directed_q.push_back(reg_row(REG_ROI_WIDTH, 16'd1));
        directed_q.push_back(reg_row(REG_ROI_HEIGHT, 16'd1));
        directed_q.push_back(known_row(16'hFFFF, 1'b1, '{0, 0, 1'b1, 16'hFFFF, 36'hFFFF}));
        directed_q.push_back(known_row(16'h0000, 1'b0, '{0, 0, 1'b0, 0, 0}));
        directed_q.push_back(known_row(16'h0001, 1'b1, '{0, 0, 1'b1, 16'h0001, 36'h1}));
        // top threshold zeroes everything
        directed_q.push_back(reg_row(REG_THRESHOLD, 16'hFFFF));
        directed_q.push_back(known_row(16'hFFFF, 1'b1, '{0, 0, 1'b0, 0, 0}));
        // pixels at the threshold drop, just above survive; spare index is ignored
        directed_q.push_back(reg_row(REG_THRESHOLD, 16'd100));
        directed_q.push_back(reg_row(REG_ROI_WIDTH, 16'd2));
        directed_q.push_back(reg_row(REG_ROI_HEIGHT, 16'd2));
        directed_q.push_back(reg_row(REG_SPARE, 16'h5A5A));
        directed_q.push_back(pix_row(16'd101, 1'b1));
        directed_q.push_back(pix_row(16'd100, 1'b0));
        directed_q.push_back(pix_row(16'd0, 1'b0));
        directed_q.push_back(pix_row(16'hFFFF, 1'b0));
        // width of zero in the low bits reads as one column
        directed_q.push_back(reg_row(REG_THRESHOLD, 16'd0));
        directed_q.push_back(reg_row(REG_ROI_WIDTH, 16'hF800));
        directed_q.push_back(pix_row(16'd5, 1'b1));
        directed_q.push_back(pix_row(16'd7, 1'b0));
        // size shrinks mid region: column wraps, then row ends the region
        directed_q.push_back(reg_row(REG_ROI_WIDTH, 16'd4));
        directed_q.push_back(reg_row(REG_ROI_HEIGHT, 16'd4));
        directed_q.push_back(pix_row(16'd9, 1'b1));
        directed_q.push_back(pix_row(16'd8, 1'b0));
        directed_q.push_back(pix_row(16'd7, 1'b0));
        directed_q.push_back(reg_row(REG_ROI_WIDTH, 16'd2));
        directed_q.push_back(pix_row(16'd6, 1'b0));
        directed_q.push_back(pix_row(16'd5, 1'b0));
        directed_q.push_back(pix_row(16'd4, 1'b0));
        directed_q.push_back(reg_row(REG_ROI_HEIGHT, 16'd1));
        directed_q.push_back(pix_row(16'd3, 1'b0));
        directed_q.push_back(pix_row(16'd2, 1'b0));
        // no frame flag, and an exact half that rounds up
        directed_q.push_back(pix_row(16'd511, 1'b0));
        directed_q.push_back(known_row(16'd1, 1'b0, '{18'd1, 0, 1'b1, 16'd511, 36'd512}));
        // frame flag in the middle restarts the sums
        directed_q.push_back(pix_row(16'd200, 1'b0));
        directed_q.push_back(pix_row(16'd50, 1'b1));
        directed_q.push_back(pix_row(16'd60, 1'b0));

        quiet = 1'b0;
        foreach (directed_q[k]) begin
            row = directed_q[k];
            if (row.kind == ROW_REG) begin
                if (!quiet) begin
                    settle();
                end
                quiet = 1'b1;
                write_reg(row.idx, row.data);
            end else begin
                quiet = 1'b0;
                i_cfg_valid <= 1'b0;
                push_pixel(row.pix, row.first, row.typed, row.want);
            end
        end

        // random phases: new settings, then a batch of regions
        rnd_pixels = 0;
        while (rnd_pixels < RANDOM_PIXELS) begin
            settle();

            r = $urandom_range(0, 9);
            if (r < 3) tv = '0;
            else if (r == 3) tv = '1;
            else if (r < 7) tv = THR_W'($urandom_range(0, 300));
            else tv = THR_W'($urandom);
            write_reg(REG_THRESHOLD, tv);

            r = $urandom_range(0, 39);
            if (r == 0) begin
                wv = '0;
                hv = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            end else if (r == 1) begin
                wv = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
                hv = $urandom_range(0, 1) ? 11'd0 : 11'd1;
            end else if (r == 2) begin
                wv = 11'd1;
                hv = 11'd1;
            end else begin
                wv = DIM_W'($urandom_range(1, 8));
                hv = DIM_W'($urandom_range(1, 8));
            end
            junk = 5'($urandom);
            write_reg(REG_ROI_WIDTH, {junk, wv});
            junk = 5'($urandom);
            write_reg(REG_ROI_HEIGHT, {junk, hv});
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            end
            i_cfg_valid <= 1'b0;

            area = side_of(width_cfg) * side_of(height_cfg);
            regions = (area > 64) ? 1 : $urandom_range(2, 10);
            repeat (regions) begin
                // mostly whole regions, some cut or overlong, some with a stray frame flag
                mode = $urandom_range(0, 99);
                if (mode < 80) n = area;
                else if (mode < 90) n = $urandom_range(1, 2 * area);
                else n = $urandom_range(1, area);
                for (int k = 0; k < n; k++) begin
                    if (mode < 80) first = (k == 0);
                    else if (mode < 90) first = (k == 0) && $urandom_range(0, 1);
                    else first = ($urandom_range(0, 7) == 0);
                    r = $urandom_range(0, 9);
                    if (r == 0) pix = '0;
                    else if (r == 1) pix = '1;
                    else if (r < 5) pix = PIX_W'($urandom_range(0, 255));
                    else pix = PIX_W'($urandom);
                    calm = (rnd_pixels >= 700) && (rnd_pixels < 1000);
                    push_pixel(pix, first, 1'b0, '0);
                    rnd_pixels++;
                end
            end
        end

        settle();
        if (err_count == 0 && spot_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
